// ===== design/rcpc_pkg.sv =====
`timescale 1ns / 1ps

package rcpc_pkg;

  localparam int MaxInBits = 512;

  localparam int ModeW = 3;
  localparam int PhaseW = 5;
  localparam int GroupW = 9;
  localparam int SkipW = 7;
  localparam int PosW = 11;
  localparam int ProdW = 14;
  localparam int DataW = 32;
  localparam int AddrW = 2;

  localparam logic [ModeW-1:0] MODE_2_3 = 3'd0;
  localparam logic [ModeW-1:0] MODE_1_3 = 3'd1;
  localparam logic [ModeW-1:0] MODE_292 = 3'd2;
  localparam logic [ModeW-1:0] MODE_148 = 3'd3;
  localparam logic [ModeW-1:0] MODE_112 = 3'd4;
  localparam logic [ModeW-1:0] MODE_72 = 3'd5;
  localparam logic [ModeW-1:0] MODE_38 = 3'd6;

  localparam logic [SkipW-1:0] SKIP_292 = 7'd65;
  localparam logic [SkipW-1:0] SKIP_148 = 7'd35;

  typedef enum logic [2:0] {
    TAB_2_3,
    TAB_1_3,
    TAB_8_12,
    TAB_8_18,
    TAB_8_17
  } tab_sel_t;

  typedef struct packed {
    tab_sel_t tab;
    logic [PhaseW-1:0] t;
    logic [PhaseW-1:0] period;
    logic [SkipW-1:0] skip;
  } scheme_t;

  function automatic scheme_t scheme_of(input logic [ModeW-1:0] mode);
    scheme_t sc;
    unique case (mode)
      MODE_1_3: sc = '{TAB_1_3, 5'd6, 5'd8, 7'd0};
      MODE_292: sc = '{TAB_2_3, 5'd3, 5'd8, SKIP_292};
      MODE_148: sc = '{TAB_1_3, 5'd6, 5'd8, SKIP_148};
      MODE_112: sc = '{TAB_8_12, 5'd3, 5'd6, 7'd0};
      MODE_72: sc = '{TAB_8_18, 5'd9, 5'd12, 7'd0};
      MODE_38: sc = '{TAB_8_17, 5'd17, 5'd24, 7'd0};
      default: sc = '{TAB_2_3, 5'd3, 5'd8, 7'd0};
    endcase
    return sc;
  endfunction

  // entry s+1 of the scheme's pattern table
  function automatic logic [PhaseW-1:0] slot_offset(input tab_sel_t tab,
                                                    input logic [PhaseW-1:0] s);
    logic [PhaseW-1:0] off;
    off = 5'd1;
    unique case (tab)
      TAB_2_3: begin
        unique case (s)
          5'd0: off = 5'd1;
          5'd1: off = 5'd2;
          default: off = 5'd5;
        endcase
      end
      TAB_1_3: begin
        unique case (s)
          5'd0: off = 5'd1;
          5'd1: off = 5'd2;
          5'd2: off = 5'd3;
          5'd3: off = 5'd5;
          5'd4: off = 5'd6;
          default: off = 5'd7;
        endcase
      end
      TAB_8_12: begin
        unique case (s)
          5'd0: off = 5'd1;
          5'd1: off = 5'd2;
          default: off = 5'd4;
        endcase
      end
      TAB_8_18: begin
        unique case (s)
          5'd0: off = 5'd1;
          5'd1: off = 5'd2;
          5'd2: off = 5'd3;
          5'd3: off = 5'd4;
          5'd4: off = 5'd5;
          5'd5: off = 5'd7;
          5'd6: off = 5'd8;
          5'd7: off = 5'd10;
          default: off = 5'd11;
        endcase
      end
      TAB_8_17: begin
        if (s < 5'd5) begin
          off = s + 5'd1;
        end else if (s[0]) begin
          off = 5'((6'(s) * 6'd3 - 6'd1) >> 1);
        end else begin
          off = 5'((6'(s) * 6'd3 - 6'd2) >> 1);
        end
      end
      default: off = 5'd1;
    endcase
    return off;
  endfunction

endpackage

// ===== design/rcpc_depuncture_mapper.sv =====
`timescale 1ns / 1ps

// RCPC depuncture mapper: takes one received hard bit per word and returns the
// zero-based mother-code slot where it belongs plus a soft value (-1 for 0,
// +1 for 1). puncture_mode (paddr is not decoded) picks the scheme: 0=2/3, 1=1/3,
// 2=292/432, 3=148/432, 4=112/168, 5=72/162, 6=38/80, 7 acts as 2/3. Set
// block_start on the first bit of each block to restart the phase counters.
// One word is accepted per clock; each result appears in the cycle after its
// word is accepted, from a single output register that keeps taking words
// as long as that register is empty or being drained. Write the mode only
// while idle; the receiver clears its mother-code buffer to erasures itself.
module rcpc_depuncture_mapper
  import rcpc_pkg::*;
#(
  parameter int MAX_IN_BITS = MaxInBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               coded_bit,
  input  logic               block_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PosW-1:0]    out_position,
  output logic signed [1:0]  soft_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  localparam int IdxW = $clog2(MAX_IN_BITS + 1);

  logic [ModeW-1:0] puncture_mode;
  logic [IdxW-1:0] item_index;
  logic [PhaseW-1:0] slot_phase;
  logic [GroupW-1:0] group_count;
  logic [SkipW-1:0] skip_phase;

  logic [IdxW-1:0] item_index_next;
  logic [PhaseW-1:0] slot_phase_next;
  logic [GroupW-1:0] group_count_next;
  logic [SkipW-1:0] skip_phase_next;

  scheme_t sc;
  logic accept;
  logic [PhaseW-1:0] s_in;
  logic [PhaseW-1:0] s_eff;
  logic [GroupW-1:0] g_in;
  logic [SkipW-1:0] sp_in;
  logic [SkipW-1:0] sp_eff;
  logic [IdxW-1:0] idx_in;
  logic wrap;
  logic [PhaseW:0] s_sum;
  logic [ProdW-1:0] pos_full;

  assign pready = 1'b1;
  assign prdata = DataW'(puncture_mode);
  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  always_comb begin
    sc = scheme_of(puncture_mode);
    s_in = block_start ? '0 : slot_phase;
    g_in = block_start ? '0 : group_count;
    sp_in = block_start ? '0 : skip_phase;
    idx_in = block_start ? '0 : item_index;

    s_eff = (s_in >= sc.t) ? '0 : s_in;
    pos_full = ProdW'(sc.period) * ProdW'(g_in)
             + ProdW'(slot_offset(sc.tab, s_eff)) - ProdW'(1);

    sp_eff = (sp_in >= sc.skip) ? '0 : sp_in;
    wrap = (sc.skip != '0) && (sp_eff == sc.skip - SkipW'(1));
    if (sc.skip == '0) begin
      skip_phase_next = sp_in;
    end else if (wrap) begin
      skip_phase_next = '0;
    end else begin
      skip_phase_next = sp_eff + SkipW'(1);
    end

    s_sum = {1'b0, s_eff} + (wrap ? (PhaseW+1)'(2) : (PhaseW+1)'(1));
    if (s_sum >= {1'b0, sc.t}) begin
      slot_phase_next = PhaseW'(s_sum - {1'b0, sc.t});
      group_count_next = g_in + GroupW'(1);
    end else begin
      slot_phase_next = PhaseW'(s_sum);
      group_count_next = g_in;
    end

    item_index_next = (idx_in < IdxW'(MAX_IN_BITS)) ? idx_in + IdxW'(1) : idx_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      puncture_mode <= MODE_2_3;
    end else if (psel && penable && pwrite) begin
      puncture_mode <= pwdata[ModeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_index <= '0;
      slot_phase <= '0;
      group_count <= '0;
      skip_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        item_index <= item_index_next;
        slot_phase <= slot_phase_next;
        group_count <= group_count_next;
        skip_phase <= skip_phase_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_position <= pos_full[PosW-1:0];
      soft_value <= coded_bit ? 2'sb01 : 2'sb11;
    end
  end

endmodule
